// File: rtl/core/circle_window_edge_fraction_defines.svh
// assertion macros shared by the block
`ifndef CIRCLE_WINDOW_EDGE_FRACTION_DEFINES_SVH
`define CIRCLE_WINDOW_EDGE_FRACTION_DEFINES_SVH

// same-cycle implication, checking held off while reset is low
`define CWEF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, checking held off while reset is low
`define CWEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: rtl/core/cwef_pkg.sv
`default_nettype none
package cwef_pkg;
    localparam int MAX_ANGLES = 256;
    localparam int ADDR_W     = $clog2(MAX_ANGLES);
    localparam int CNT_W      = $clog2(MAX_ANGLES + 1);
    localparam int RS_W       = 25;
    localparam int RS2_W      = 2 * RS_W;
    localparam int DEN_W      = RS2_W + CNT_W;
    localparam int REM_W      = DEN_W + 1;
    localparam int Q_W        = 48;
    localparam int STEP_W     = 6;
    localparam int RAY_STEPS  = 48;
    localparam int FRAC_STEPS = 16;
    localparam int TAB_W      = 32;

    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_LEFT   = 3'd1;
    localparam logic [2:0] REG_RIGHT  = 3'd2;
    localparam logic [2:0] REG_BOTTOM = 3'd3;
    localparam logic [2:0] REG_TOP    = 3'd4;
    localparam logic [2:0] REG_COUNT  = 3'd5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [REM_W-1:0]  rem_init;
        logic [Q_W-1:0]    dividend;
        logic [REM_W-1:0]  divisor;
    } div_req_t;
endpackage
`default_nettype wire

// File: rtl/core/cwef_ram.sv
`default_nettype none
module cwef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: rtl/core/cwef_div.sv
`default_nettype none
// shared restoring divider, one quotient bit a cycle
module cwef_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cwef_pkg::div_req_t        req,
    output logic                           done,
    output logic [cwef_pkg::Q_W-1:0]       quot
);
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [cwef_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [cwef_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [cwef_pkg::REM_W-1:0]    dvs_reg, dvs_next;
    logic [cwef_pkg::Q_W-1:0]      dvd_reg, dvd_next;
    logic [cwef_pkg::Q_W-1:0]      quot_reg, quot_next;
    logic [cwef_pkg::REM_W-1:0]    trial;

    always_comb begin
        trial      = {rem_reg[cwef_pkg::REM_W-2:0], dvd_reg[cwef_pkg::Q_W-1]};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            dvs_next  = req.divisor;
            dvd_next  = req.dividend;
            quot_next = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[cwef_pkg::Q_W-2:0], 1'b0};
            if (trial >= dvs_reg) begin
                rem_next  = trial - dvs_reg;
                quot_next = {quot_reg[cwef_pkg::Q_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[cwef_pkg::Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cwef_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// File: rtl/core/circle_window_edge_fraction.sv
// a table write lands in the angle table on acceptance; an interior point or zero radius goes
// from S_CHECK to S_OUT; others pass S_DEN1, S_DEN2, per angle S_FETCH, S_ANG, S_STX,
// a division per nonzero direction component, S_SQ, S_ACC, then S_FRST and a fraction division
// unless the sum saturates, on the shared bit-serial divider; one point at a time: s_tready
// is low from accepting an eval until the result enters the output reg, which awaits m_tready
// reset: synchronous active-low aresetn resets control and configuration, not the angle table
`default_nettype none
`include "circle_window_edge_fraction_defines.svh"
module circle_window_edge_fraction (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // angle_index[7:0], cos_value[23:8], sin_value[39:24],
                                        // x_pos[71:40], y_pos[103:72]
    input  wire logic         s_tuser,  // action
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,  // fraction[16:0], zero fill above
    output logic              m_tuser,  // interior
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DEN1  = 4'd2;
    localparam logic [3:0] S_DEN2  = 4'd3;
    localparam logic [3:0] S_FETCH = 4'd4;
    localparam logic [3:0] S_ANG   = 4'd5;
    localparam logic [3:0] S_STX   = 4'd6;
    localparam logic [3:0] S_DIVX  = 4'd7;
    localparam logic [3:0] S_DIVY  = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_FRST  = 4'd11;
    localparam logic [3:0] S_FRAC  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam logic [16:0] ONE = 17'd65536;

    // configuration registers
    logic [30:0]                radius_reg;
    logic signed [31:0]         left_reg, right_reg, bottom_reg, top_reg;
    logic [cwef_pkg::CNT_W-1:0] count_reg;

    // sequencer and datapath registers
    logic [3:0]                 state_reg, state_next;
    logic signed [31:0]         x_reg, x_next, y_reg, y_next;
    logic [cwef_pkg::CNT_W-1:0] n_reg, n_next, k_reg, k_next;
    logic [2:0]                 sh_reg, sh_next;
    logic [cwef_pkg::RS_W-1:0]  rs_reg, rs_next;
    logic [cwef_pkg::RS2_W-1:0] rs2_reg, rs2_next;
    logic [cwef_pkg::DEN_W-1:0] den_reg, den_next;
    logic [cwef_pkg::DEN_W-1:0] sum_reg, sum_next;
    logic signed [15:0]         c_reg, c_next, s_reg, s_next;
    logic                       have_reg, have_next;
    logic signed [48:0]         best_reg, best_next;
    logic [63:0]                prod_reg, prod_next;
    logic [16:0]                frac_reg, frac_next;
    logic                       int_reg, int_next;
    logic                       m_valid_reg, m_valid_next;
    logic [16:0]                m_frac_reg, m_frac_next;
    logic                       m_int_reg, m_int_next;

    logic                       in_acc, wr_en;
    logic [cwef_pkg::TAB_W-1:0] rd_data;
    cwef_pkg::div_req_t         dreq;
    logic                       div_done;
    logic [cwef_pkg::Q_W-1:0]   div_q;

    // combinational helpers
    logic signed [33:0]         r_s, gx_r, gx_l, gy_t, gy_b;
    logic                       interior;
    logic [2:0]                 sh_calc;
    logic                       use_y;
    logic signed [15:0]         dir;
    logic signed [33:0]         gap;
    logic [32:0]                gmag;
    logic [15:0]                dmag;
    logic                       qneg;
    logic signed [48:0]         dval;
    logic signed [48:0]         reff;
    logic [47:0]                rmag, rmag_sh;
    logic [31:0]                m_val;
    logic [63:0]                sq_c;
    logic [cwef_pkg::DEN_W:0]   acc;
    logic                       out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign wr_en     = in_acc && (s_tuser == cwef_pkg::ACT_WRITE)
                       && ({1'b0, s_tdata[7:0]} < 9'(cwef_pkg::MAX_ANGLES));
    assign out_free  = !m_valid_reg || m_tready;

    cwef_ram #(
        .WIDTH (cwef_pkg::TAB_W),
        .DEPTH (cwef_pkg::MAX_ANGLES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cwef_pkg::ADDR_W'(s_tdata[7:0])),
        .wr_data ({s_tdata[23:8], s_tdata[39:24]}),
        .rd_addr (k_reg[cwef_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    cwef_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .done    (div_done),
        .quot    (div_q)
    );

    // configuration transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 31'd65536;
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            top_reg    <= '0;
            count_reg  <= cwef_pkg::CNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cwef_pkg::REG_RADIUS: radius_reg <= cfg_data[30:0];
                cwef_pkg::REG_LEFT:   left_reg   <= cfg_data;
                cwef_pkg::REG_RIGHT:  right_reg  <= cfg_data;
                cwef_pkg::REG_BOTTOM: bottom_reg <= cfg_data;
                cwef_pkg::REG_TOP:    top_reg    <= cfg_data;
                cwef_pkg::REG_COUNT:  count_reg  <= cfg_data[cwef_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // distances to each edge, 34 bit so nothing wraps
        r_s      = 34'(signed'({1'b0, radius_reg}));
        gx_r     = 34'(right_reg) - 34'(x_reg);
        gx_l     = 34'(left_reg) - 34'(x_reg);
        gy_t     = 34'(top_reg) - 34'(y_reg);
        gy_b     = 34'(bottom_reg) - 34'(y_reg);
        interior = (gx_r >= r_s) && (-gx_l >= r_s) && (gy_t >= r_s) && (-gy_b >= r_s);

        // shift that keeps the scaled radius within 25 bits
        sh_calc = '0;
        for (int i = 25; i < 31; i++) begin
            if (radius_reg[i]) begin
                sh_calc = 3'(i - 24);
            end
        end

        // ray division operands: x side first, then y side
        use_y = (state_reg == S_DIVX) || (state_reg == S_STX && c_reg == '0);
        dir   = use_y ? s_reg : c_reg;
        if (use_y) begin
            gap = (s_reg > 0) ? gy_t : gy_b;
        end else begin
            gap = (c_reg > 0) ? gx_r : gx_l;
        end
        gmag = gap[33] ? 33'(-gap) : 33'(gap);
        dmag = dir[15] ? 16'(-dir) : 16'(dir);
        // sign taken at the division's end, operands still held
        if (state_reg == S_DIVY) begin
            qneg = ((s_reg > 0) ? gy_t[33] : gy_b[33]) ^ s_reg[15];
        end else begin
            qneg = ((c_reg > 0) ? gx_r[33] : gx_l[33]) ^ c_reg[15];
        end
        dval = qneg ? -49'(signed'({1'b0, div_q})) : 49'(signed'({1'b0, div_q}));

        dreq = '0;
        unique case (state_reg)
            S_STX: begin
                dreq.start = (c_reg != '0) || (s_reg != '0);
            end
            S_DIVX: begin
                dreq.start = div_done && (s_reg != '0);
            end
            S_FRST: begin
                dreq.start = (sum_reg < den_reg);
            end
            default: ;
        endcase
        if (state_reg == S_FRST) begin
            dreq.steps    = cwef_pkg::STEP_W'(cwef_pkg::FRAC_STEPS);
            dreq.rem_init = cwef_pkg::REM_W'(sum_reg);
        end else begin
            dreq.steps    = cwef_pkg::STEP_W'(cwef_pkg::RAY_STEPS);
            dreq.dividend = {1'b0, gmag, 14'd0};
            dreq.divisor  = cwef_pkg::REM_W'(dmag);
        end
        if (state_reg == S_FRST) begin
            dreq.divisor = cwef_pkg::REM_W'(den_reg);
        end

        // clamped effective radius and its scaled magnitude
        reff    = (have_reg && best_reg < 49'(signed'({1'b0, radius_reg})))
                  ? best_reg : 49'(signed'({1'b0, radius_reg}));
        rmag    = reff[48] ? 48'(-reff) : 48'(reff);
        rmag_sh = rmag >> sh_reg;
        m_val   = (rmag_sh > 48'h8000_0000) ? 32'h8000_0000 : rmag_sh[31:0];

        sq_c = (prod_reg > 64'(den_reg)) ? 64'(den_reg) : prod_reg;
        acc  = {1'b0, sum_reg} + sq_c[cwef_pkg::DEN_W:0];
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        sh_next      = sh_reg;
        rs_next      = rs_reg;
        rs2_next     = rs2_reg;
        den_next     = den_reg;
        sum_next     = sum_reg;
        c_next       = c_reg;
        s_next       = s_reg;
        have_next    = have_reg;
        best_next    = best_reg;
        prod_next    = prod_reg;
        frac_next    = frac_reg;
        int_next     = int_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_frac_next  = m_frac_reg;
        m_int_next   = m_int_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && s_tuser == cwef_pkg::ACT_EVAL) begin
                    x_next     = s_tdata[71:40];
                    y_next     = s_tdata[103:72];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // out-of-range counts fold into 1..MAX_ANGLES
                if (count_reg == '0) begin
                    n_next = cwef_pkg::CNT_W'(1);
                end else if (count_reg > cwef_pkg::CNT_W'(cwef_pkg::MAX_ANGLES)) begin
                    n_next = cwef_pkg::CNT_W'(cwef_pkg::MAX_ANGLES);
                end else begin
                    n_next = count_reg;
                end
                sh_next = sh_calc;
                rs_next = cwef_pkg::RS_W'(radius_reg >> sh_calc);
                if (interior) begin
                    frac_next  = ONE;
                    int_next   = 1'b1;
                    state_next = S_OUT;
                end else if (radius_reg == '0) begin
                    frac_next  = '0;
                    int_next   = 1'b0;
                    state_next = S_OUT;
                end else begin
                    int_next   = 1'b0;
                    state_next = S_DEN1;
                end
            end
            S_DEN1: begin
                rs2_next   = rs_reg * rs_reg;
                state_next = S_DEN2;
            end
            S_DEN2: begin
                den_next   = rs2_reg * n_reg;
                k_next     = '0;
                sum_next   = '0;
                state_next = S_FETCH;
            end
            S_FETCH: begin
                state_next = S_ANG;
            end
            S_ANG: begin
                c_next     = rd_data[31:16];
                s_next     = rd_data[15:0];
                have_next  = 1'b0;
                state_next = S_STX;
            end
            S_STX: begin
                if (c_reg != '0) begin
                    state_next = S_DIVX;
                end else if (s_reg != '0) begin
                    state_next = S_DIVY;
                end else begin
                    state_next = S_SQ;
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    have_next  = 1'b1;
                    best_next  = dval;
                    state_next = (s_reg != '0) ? S_DIVY : S_SQ;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    if (!have_reg || dval < best_reg) begin
                        best_next = dval;
                    end
                    have_next  = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                prod_next  = m_val * m_val;
                state_next = S_ACC;
            end
            S_ACC: begin
                sum_next   = (acc > {1'b0, den_reg}) ? den_reg : acc[cwef_pkg::DEN_W-1:0];
                k_next     = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 == n_reg) ? S_FRST : S_FETCH;
            end
            S_FRST: begin
                if (sum_reg >= den_reg) begin
                    frac_next  = ONE;
                    state_next = S_OUT;
                end else begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC: begin
                if (div_done) begin
                    frac_next  = {1'b0, div_q[15:0]};
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // result waits here only while the output register is full and m_tready is low
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_frac_next  = frac_reg;
                    m_int_next   = int_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            have_reg    <= have_next;
            k_reg       <= k_next;
        end
        x_reg      <= x_next;
        y_reg      <= y_next;
        n_reg      <= n_next;
        sh_reg     <= sh_next;
        rs_reg     <= rs_next;
        rs2_reg    <= rs2_next;
        den_reg    <= den_next;
        sum_reg    <= sum_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
        best_reg   <= best_next;
        prod_reg   <= prod_next;
        frac_reg   <= frac_next;
        int_reg    <= int_next;
        m_frac_reg <= m_frac_next;
        m_int_reg  <= m_int_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_frac_reg};
    assign m_tuser  = m_int_reg;

    `CWEF_ASSERT_NOW(a_frac_range, aclk, aresetn, m_tvalid, m_tdata[16:0] <= ONE)
    `CWEF_ASSERT_NOW(a_interior_full, aclk, aresetn, m_tvalid && m_tuser, m_tdata[16:0] == ONE)
    `CWEF_ASSERT_NEXT(a_eval_busy, aclk, aresetn,
        s_tvalid && s_tready && s_tuser == cwef_pkg::ACT_EVAL, !s_tready)
    `CWEF_ASSERT_NOW(a_sum_bound, aclk, aresetn, state_reg == S_FRST, sum_reg <= den_reg)
endmodule
`default_nettype wire
